@@ src/sfpe_pkg.sv @@
`timescale 1ns / 1ps

package sfpe_pkg;

  // Message geometry.
  localparam int unsigned MAX_DATA_NIBBLES = 6;
  localparam int unsigned NIBBLE_W         = 4;
  localparam int unsigned COUNT_W          = 3;
  localparam int unsigned TICKS_W          = 12;
  localparam int unsigned RATIO_W          = 12;
  localparam int unsigned PERIOD_W         = 24;
  localparam int unsigned KIND_W           = 3;
  localparam int unsigned PULSE_IDX_W      = 4;
  localparam int unsigned TOTAL_W          = 9;

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  // Queue between the front and the back.
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Pulse timing in SENT ticks.
  localparam logic [TICKS_W-1:0]  SYNC_TICKS        = TICKS_W'(56);
  localparam logic [TICKS_W-1:0]  NIBBLE_BASE_TICKS = TICKS_W'(12);
  localparam logic [NIBBLE_W-1:0] CRC4_SEED         = NIBBLE_W'(5);

  // Register reset values.
  localparam logic [RATIO_W-1:0] TICK_RATIO_RST  = RATIO_W'(1);
  localparam logic [TICKS_W-1:0] FRAME_TICKS_RST = TICKS_W'(0);
  localparam logic [COUNT_W-1:0] DATA_COUNT_RST  = COUNT_W'(MAX_DATA_NIBBLES);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TICK_RATIO   = 2'd0,
    CFG_PAUSE_ENABLE = 2'd1,
    CFG_FRAME_TICKS  = 2'd2,
    CFG_DATA_COUNT   = 2'd3
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SYNC   = 3'd0,
    KIND_STATUS = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_CRC    = 3'd3,
    KIND_PAUSE  = 3'd4
  } kind_e;

  // One classified message, as handed from the front to the back.
  typedef struct packed {
    logic [NIBBLE_W-1:0]                        status;
    logic [MAX_DATA_NIBBLES-1:0][NIBBLE_W-1:0]  nib;
    logic [COUNT_W-1:0]                         count;
    logic [NIBBLE_W-1:0]                        crc;
    logic [TICKS_W-1:0]                         fill;
    logic [RATIO_W-1:0]                         ratio;
    logic                                       pause_en;
  } msg_t;

  // CRC4 step table.
  function automatic logic [NIBBLE_W-1:0] crc4_lut(input logic [NIBBLE_W-1:0] idx);
    logic [NIBBLE_W-1:0] r;
    case (idx)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd13;
      4'd2:    r = 4'd7;
      4'd3:    r = 4'd10;
      4'd4:    r = 4'd14;
      4'd5:    r = 4'd3;
      4'd6:    r = 4'd9;
      4'd7:    r = 4'd4;
      4'd8:    r = 4'd1;
      4'd9:    r = 4'd12;
      4'd10:   r = 4'd6;
      4'd11:   r = 4'd11;
      4'd12:   r = 4'd15;
      4'd13:   r = 4'd2;
      4'd14:   r = 4'd8;
      default: r = 4'd5;
    endcase
    return r;
  endfunction

endpackage

@@ src/sfpe_front.sv @@
`timescale 1ns / 1ps

module sfpe_front (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                cfg_valid_i,
  input  logic [sfpe_pkg::CFG_INDEX_W-1:0]                    cfg_index_i,
  input  logic [sfpe_pkg::CFG_DATA_W-1:0]                     cfg_data_i,
  input  logic [sfpe_pkg::NIBBLE_W-1:0]                       status_i,
  input  logic [sfpe_pkg::MAX_DATA_NIBBLES-1:0][sfpe_pkg::NIBBLE_W-1:0] nib_i,
  output sfpe_pkg::msg_t                                      msg_o
);
  import sfpe_pkg::*;

  logic [RATIO_W-1:0] tick_ratio_q;
  logic               pause_enable_q;
  logic [TICKS_W-1:0] frame_ticks_q;
  logic [COUNT_W-1:0] data_count_q;

  logic [COUNT_W-1:0]  count;
  logic [NIBBLE_W-1:0] crc;
  logic [TOTAL_W-1:0]  total;
  logic [TICKS_W-1:0]  total_ext;

  // Configuration registers; the port is always ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ratio_q   <= TICK_RATIO_RST;
      pause_enable_q <= 1'b0;
      frame_ticks_q  <= FRAME_TICKS_RST;
      data_count_q   <= DATA_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TICK_RATIO:   tick_ratio_q   <= cfg_data_i[RATIO_W-1:0];
        CFG_PAUSE_ENABLE: pause_enable_q <= cfg_data_i[0];
        CFG_FRAME_TICKS:  frame_ticks_q  <= cfg_data_i[TICKS_W-1:0];
        CFG_DATA_COUNT:   data_count_q   <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective data count, saturated at the maximum.
  assign count = (data_count_q > COUNT_W'(MAX_DATA_NIBBLES)) ?
                 COUNT_W'(MAX_DATA_NIBBLES) : data_count_q;

  // CRC4 over the nibbles in use, then one zero-nibble augmentation step.
  // Frame length in ticks for everything but the pause.
  always_comb begin
    logic [NIBBLE_W-1:0] c;
    logic [TOTAL_W-1:0]  t;
    c = CRC4_SEED;
    t = TOTAL_W'(SYNC_TICKS) + TOTAL_W'(NIBBLE_BASE_TICKS) + TOTAL_W'(status_i);
    for (int i = 0; i < MAX_DATA_NIBBLES; i++) begin
      if (COUNT_W'(i) < count) begin
        c = nib_i[i] ^ crc4_lut(c);
        t = t + TOTAL_W'(NIBBLE_BASE_TICKS) + TOTAL_W'(nib_i[i]);
      end
    end
    c = crc4_lut(c);
    crc   = c;
    total = t + TOTAL_W'(NIBBLE_BASE_TICKS) + TOTAL_W'(c);
  end

  assign total_ext = TICKS_W'(total);

  // Classified message toward the queue.
  always_comb begin
    msg_o.status   = status_i;
    msg_o.nib      = nib_i;
    msg_o.count    = count;
    msg_o.crc      = crc;
    msg_o.fill     = (frame_ticks_q > total_ext) ? (frame_ticks_q - total_ext) : '0;
    msg_o.ratio    = (tick_ratio_q == '0) ? TICK_RATIO_RST : tick_ratio_q;
    msg_o.pause_en = pause_enable_q;
  end

endmodule

@@ src/sfpe_fifo.sv @@
`timescale 1ns / 1ps

module sfpe_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfpe_pkg::msg_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output sfpe_pkg::msg_t head_o
);
  import sfpe_pkg::*;

  msg_t                  entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o       = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/sfpe_back.sv @@
`timescale 1ns / 1ps

module sfpe_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  input  sfpe_pkg::msg_t                      head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [sfpe_pkg::PERIOD_W-1:0]       period_counts_o,
  output logic [sfpe_pkg::KIND_W-1:0]         pulse_kind_o,
  output logic [sfpe_pkg::NIBBLE_W-1:0]       crc_nibble_o,
  output logic                                last_pulse_o
);
  import sfpe_pkg::*;

  logic [PULSE_IDX_W-1:0] idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  logic [PERIOD_W-1:0]    period_q;
  kind_e                  kind_q;
  logic [NIBBLE_W-1:0]    crc_q;
  logic                   last_q;

  logic [PULSE_IDX_W-1:0] count_ext;
  logic [PULSE_IDX_W-1:0] last_idx;
  logic [COUNT_W-1:0]     data_sel;
  logic [NIBBLE_W-1:0]    data_nib;
  kind_e                  kind;
  logic [TICKS_W-1:0]     ticks;
  logic                   is_last;
  logic                   advance, fire;

  assign count_ext = PULSE_IDX_W'(head_i.count);
  assign last_idx  = count_ext + PULSE_IDX_W'(2) + PULSE_IDX_W'(head_i.pause_en);
  assign is_last   = (idx_q == last_idx);
  assign data_sel  = COUNT_W'(idx_q - PULSE_IDX_W'(2));

  // Data nibble for the current data pulse.
  always_comb begin
    case (data_sel)
      3'd0:    data_nib = head_i.nib[0];
      3'd1:    data_nib = head_i.nib[1];
      3'd2:    data_nib = head_i.nib[2];
      3'd3:    data_nib = head_i.nib[3];
      3'd4:    data_nib = head_i.nib[4];
      3'd5:    data_nib = head_i.nib[5];
      default: data_nib = '0;
    endcase
  end

  // Pulse kind and length in ticks for the current position in the frame.
  always_comb begin
    if (idx_q == '0) begin
      kind  = KIND_SYNC;
      ticks = SYNC_TICKS;
    end else if (idx_q == PULSE_IDX_W'(1)) begin
      kind  = KIND_STATUS;
      ticks = NIBBLE_BASE_TICKS + TICKS_W'(head_i.status);
    end else if (idx_q < count_ext + PULSE_IDX_W'(2)) begin
      kind  = KIND_DATA;
      ticks = NIBBLE_BASE_TICKS + TICKS_W'(data_nib);
    end else if (idx_q == count_ext + PULSE_IDX_W'(2)) begin
      kind  = KIND_CRC;
      ticks = NIBBLE_BASE_TICKS + TICKS_W'(head_i.crc);
    end else begin
      kind  = KIND_PAUSE;
      ticks = head_i.fill;
    end
  end

  // A pulse moves into the output register when it is empty or being taken.
  assign advance = !out_valid_q || !out_stall_i;
  assign fire    = advance && head_valid_i;
  assign pop_o   = fire && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      idx_d       = is_last ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload; the period product is formed straight into the register.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      period_q <= PERIOD_W'(ticks) * PERIOD_W'(head_i.ratio);
      kind_q   <= kind;
      crc_q    <= head_i.crc;
      last_q   <= is_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign period_counts_o = period_q;
  assign pulse_kind_o    = kind_q;
  assign crc_nibble_o    = crc_q;
  assign last_pulse_o    = last_q;

endmodule

@@ src/sent_frame_pulse_encoder.sv @@
`timescale 1ns / 1ps

// SENT fast-channel frame encoder.
// Input channel (in_valid_i / in_stall_o): one beat is one message, a status
// nibble and six data nibbles. The front computes the CRC4 and the pause fill
// and writes the message into a two-entry queue.
// Output channel (out_valid_o / out_stall_i): one beat per pulse, in the order
// sync, status, data nibbles, CRC and optional pause, with last_pulse_o set on
// the final pulse of the frame. Periods are ticks times the tick ratio.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready and must only be
// written while no message is in flight.
// A message is first written into the queue; its first pulse then enters the
// output register once that is empty or being taken. The output sequencer
// issues one pulse per cycle while the output is not stalled; a message has
// the saturated data count plus 3 pulses, plus one with the pause enabled (at
// most 10). Messages are accepted back to back while the queue has room.
// When the receiver stalls, the held pulse stays put and the queue fills, after
// which in_stall_o rises. Reset empties the queue and loads register defaults
// (tick ratio 1, pause off, frame length 0, six data nibbles).
module sent_frame_pulse_encoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sfpe_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [sfpe_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [sfpe_pkg::NIBBLE_W-1:0]      status_nibble_i,
  input  logic [sfpe_pkg::NIBBLE_W-1:0]      nibble_0_i,
  input  logic [sfpe_pkg::NIBBLE_W-1:0]      nibble_1_i,
  input  logic [sfpe_pkg::NIBBLE_W-1:0]      nibble_2_i,
  input  logic [sfpe_pkg::NIBBLE_W-1:0]      nibble_3_i,
  input  logic [sfpe_pkg::NIBBLE_W-1:0]      nibble_4_i,
  input  logic [sfpe_pkg::NIBBLE_W-1:0]      nibble_5_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [sfpe_pkg::PERIOD_W-1:0]      period_counts_o,
  output logic [sfpe_pkg::KIND_W-1:0]        pulse_kind_o,
  output logic [sfpe_pkg::NIBBLE_W-1:0]      crc_nibble_o,
  output logic                               last_pulse_o
);
  import sfpe_pkg::*;

  logic [MAX_DATA_NIBBLES-1:0][NIBBLE_W-1:0] nib;
  msg_t front_msg;
  msg_t head_msg;
  logic fifo_full;
  logic head_valid;
  logic pop;

  assign nib = {nibble_5_i, nibble_4_i, nibble_3_i, nibble_2_i, nibble_1_i, nibble_0_i};
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = fifo_full;

  // Front: configuration, CRC and pause fill.
  sfpe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .status_i    (status_nibble_i),
    .nib_i       (nib),
    .msg_o       (front_msg)
  );

  // Message queue between front and back.
  sfpe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_data_i  (front_msg),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_msg)
  );

  // Back: pulse sequencer and output register.
  sfpe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head_msg),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .period_counts_o (period_counts_o),
    .pulse_kind_o    (pulse_kind_o),
    .crc_nibble_o    (crc_nibble_o),
    .last_pulse_o    (last_pulse_o)
  );

endmodule
